@@ rtl/depth_order_selection_sort_unit_defines.svh @@
// Assertion macros shared by the depth-order sorter RTL.
// No dependencies; included by the top level only.
`ifndef DEPTH_ORDER_SELECTION_SORT_UNIT_DEFINES_SVH
`define DEPTH_ORDER_SELECTION_SORT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DOS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("depth order sorter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("depth order sorter: next-cycle check failed");

`endif

@@ rtl/dos_pkg.sv @@
// Types shared by the depth-order sorter: word formats, the stored entry,
// and the command and status groups between controller and datapath. No dependencies.
package dos_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 8;

    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0]        item_tag;
        logic                    is_last;
    } in_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0]        sorted_tag;
        logic                    end_of_run;
        logic                    overflowed;
    } out_word_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        logic load_en;    // store the incoming word, or flag it as dropped
        logic i_clr;      // restart the outer position at zero
        logic i_inc;      // advance the outer position
        logic rd_i;       // read the entry at the outer position, point scan after it
        logic rd_j;       // read the entry at the scan index and advance it
        logic best_load;  // take the entry just read as the running maximum
        logic cmp_en;     // compare the entry just read with the running maximum
        logic swap_a;     // write the maximum into the outer position
        logic swap_b;     // write the old outer entry where the maximum was
        logic emit_start; // restart the scan index for output
        logic out_load;   // load the output register from the entry just read
        logic set_done;   // clear the fill count and overflow flag
    } dos_cmd_t;

    typedef struct packed {
        logic i_last;     // no later entries remain after the outer position
        logic j_end;      // scan index has reached the fill count
        logic out_end;    // output register holds the final word of the set
    } dos_sts_t;

endpackage

@@ rtl/dos_ctrl.sv @@
// Sequencer of the depth-order sorter: load, sort passes, emission.
// Depends on dos_pkg for the command and status groups.
module dos_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dos_pkg::dos_sts_t sts,
    output dos_pkg::dos_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_TOP,
        S_FIRST,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_ERD,
        S_EOUT,
        S_EWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        in_ready     = 1'b0;
        case (state_reg)
            S_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_en = 1'b1;
                    if (in_last) begin
                        cmd.i_clr  = 1'b1;
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP: begin
                if (sts.i_last) begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_ERD;
                end else begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_FIRST;
                end
            end
            S_FIRST: begin
                cmd.best_load = 1'b1;
                cmd.rd_j      = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                cmd.cmp_en = 1'b1;
                if (sts.j_end) begin
                    state_next = S_SWAP_A;
                end else begin
                    cmd.rd_j = 1'b1;
                end
            end
            S_SWAP_A: begin
                cmd.swap_a = 1'b1;
                state_next = S_SWAP_B;
            end
            S_SWAP_B: begin
                cmd.swap_b = 1'b1;
                cmd.i_inc  = 1'b1;
                state_next = S_TOP;
            end
            S_ERD: begin
                cmd.rd_j   = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT: begin
                cmd.out_load = 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_EWAIT;
            end
            S_EWAIT: begin
                if (out_ready) begin
                    m_valid_next = 1'b0;
                    if (sts.out_end) begin
                        cmd.set_done = 1'b1;
                        state_next   = S_LOAD;
                    end else begin
                        cmd.rd_j   = 1'b1;
                        state_next = S_EOUT;
                    end
                end
            end
            default: begin
                state_next   = S_LOAD;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_valid = m_valid_reg;

endmodule

@@ rtl/dos_datapath.sv @@
// Datapath of the depth-order sorter: entry memory, indices, running maximum
// and output register. Depends on dos_pkg for word, entry, command and status types.
module dos_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dos_pkg::dos_cmd_t   cmd,
    input  dos_pkg::in_word_t   in_word,
    output dos_pkg::dos_sts_t   sts,
    output dos_pkg::out_word_t  out_word
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    dos_pkg::entry_t mem [MAX_ITEMS];

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [AW-1:0]      pick_reg, pick_next;
    logic [AW-1:0]      rd_idx_reg;
    dos_pkg::entry_t    rd_data_reg;
    dos_pkg::entry_t    best_reg, best_next;
    dos_pkg::entry_t    ent_i_reg, ent_i_next;
    dos_pkg::out_word_t out_reg, out_next;

    logic               full;
    logic               moved;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    dos_pkg::entry_t    wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      i_plus;

    assign full   = (cnt_reg >= CW'(MAX_ITEMS));
    assign moved  = (pick_reg != i_reg);
    assign i_plus = CW'(i_reg) + 1'b1;

    assign rd_en   = cmd.rd_i | cmd.rd_j;
    assign rd_addr = cmd.rd_i ? i_reg : j_reg[AW-1:0];

    // One write port: input fill, or one half of a swap.
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = cnt_reg[AW-1:0];
        wr_data.key  = in_word.sort_key;
        wr_data.tag  = in_word.item_tag;
        if (cmd.load_en && !full) begin
            wr_en = 1'b1;
        end else if (cmd.swap_a && moved) begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_data = best_reg;
        end else if (cmd.swap_b && moved) begin
            wr_en   = 1'b1;
            wr_addr = pick_reg;
            wr_data = ent_i_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        ent_i_next = ent_i_reg;
        out_next   = out_reg;

        if (cmd.load_en) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (cmd.set_done) begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end

        if (cmd.i_clr) begin
            i_next = '0;
        end else if (cmd.i_inc) begin
            i_next = i_reg + 1'b1;
        end

        if (cmd.rd_i) begin
            j_next = i_plus;
        end else if (cmd.rd_j) begin
            j_next = j_reg + 1'b1;
        end else if (cmd.emit_start) begin
            j_next = '0;
        end

        if (cmd.best_load) begin
            best_next  = rd_data_reg;
            ent_i_next = rd_data_reg;
            pick_next  = i_reg;
        end else if (cmd.cmp_en && (rd_data_reg.key > best_reg.key)) begin
            // Strictly greater keeps the earliest position on equal keys.
            best_next = rd_data_reg;
            pick_next = rd_idx_reg;
        end

        if (cmd.out_load) begin
            out_next.sorted_key = rd_data_reg.key;
            out_next.sorted_tag = rd_data_reg.tag;
            out_next.end_of_run = (j_reg == cnt_reg);
            out_next.overflowed = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_reg  <= pick_next;
        best_reg  <= best_next;
        ent_i_reg <= ent_i_next;
        out_reg   <= out_next;
    end

    assign sts.i_last  = (i_plus >= cnt_reg);
    assign sts.j_end   = (j_reg == cnt_reg);
    assign sts.out_end = out_reg.end_of_run;

    assign out_word = out_reg;

endmodule

@@ rtl/depth_order_selection_sort_unit.sv @@
// Channel  | Ports                          | Word type
// input    | s_valid, s_ready, s_word       | dos_pkg::in_word_t  (key, tag, is_last)
// result   | m_valid, m_ready, m_word       | dos_pkg::out_word_t (key, tag, end, overflow)
//
// Top level of the depth-order sorter. Depends on dos_pkg, dos_ctrl, dos_datapath
// and the assertion macros in depth_order_selection_sort_unit_defines.svh.
//
// While loading, s_ready is high and each input word is taken as it arrives. After the
// word marked last, the set is sorted; the sort time is set by the single read port
// of the entry memory, which the scan reads one entry per cycle, and by the two
// halves of each swap, which are written one after the other.
// Emission then reads each result word into the output register and holds it there
// until m_ready takes it.
// Reset is synchronous on aresetn, active low; the entry memory is not cleared.
// s_ready is low from the last input word until the final result word is taken.
`include "depth_order_selection_sort_unit_defines.svh"

module depth_order_selection_sort_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dos_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output dos_pkg::out_word_t  m_word
);

    // Command and status groups between the sequencer and the datapath.
    dos_pkg::dos_cmd_t cmd;
    dos_pkg::dos_sts_t sts;

    // The sequencer walks the load phase, then one pass per outer position
    // (read that entry, scan every later entry, swap if a larger key was
    // found), then the output phase, one result word at a time.
    dos_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_last   (s_word.is_last),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the entry memory, the fill count, the overflow flag,
    // the outer and scan indices, the running maximum and the output register.
    dos_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_word  (s_word),
        .sts      (sts),
        .out_word (m_word)
    );

    // Loading and emission never overlap.
    `DOS_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_ready, !m_valid)

    // The word that closes a set stops further loading until the set is out.
    `DOS_ASSERT_NEXT(a_last_stops_load, aclk, aresetn, s_valid && s_ready && s_word.is_last, !s_ready)

    // Taking the final result word reopens the input side at once.
    `DOS_ASSERT_NEXT(a_end_reopens, aclk, aresetn, m_valid && m_ready && m_word.end_of_run, s_ready && !m_valid)

endmodule
